@@ rtl/astr_pkg.sv @@
// Shared types and constants for the aging state table reducer.
package astr_pkg;

    // Table geometry.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Arithmetic constants.
    localparam logic [31:0] HASH_MUL        = 32'd97;
    localparam logic [31:0] AND_SEED        = 32'd1;
    localparam logic [3:0]  AGE_LIMIT_RESET = 4'd5;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_AND  = 2'd1,
        OP_OR   = 2'd2
    } op_t;

    // Status codes of a result item.
    typedef enum logic [1:0] {
        STAT_QUERY  = 2'd0,
        STAT_STORED = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    // Token that walks the chain of cells, one cell per cycle.
    typedef struct packed {
        logic             active;
        logic             is_set;
        logic             is_and;
        logic [31:0]      key;
        logic [31:0]      data;      // new value for a set, accumulator for a query
        logic [CNT_W-1:0] cnt;
        logic             found;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
    } pass_t;

    // Write of a new entry into a free cell after a set missed.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [31:0]      key;
        logic [31:0]      value;
    } fill_t;

    // One result item.
    typedef struct packed {
        logic [31:0] reduced_value;
        status_t     status;
        logic [4:0]  live_count;
    } result_t;

endpackage

@@ rtl/astr_cell.sv @@
// One table entry with its slice of the lookup and query walk.
module astr_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [astr_pkg::IDX_W-1:0] cell_idx,
    input  logic [3:0]                age_limit,
    input  astr_pkg::pass_t           pass_in,
    input  logic                      fill_en,
    input  astr_pkg::fill_t           fill,
    output astr_pkg::pass_t           pass_out
);

    logic        valid_reg, valid_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] value_reg, value_next;
    logic [3:0]  age_reg, age_next;
    astr_pkg::pass_t pass_reg, pass_next;

    // Token visit: match or free-slot search for a set, fold and age for a query.
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        age_next   = age_reg;
        pass_next  = pass_in;
        if (pass_in.active) begin
            if (pass_in.is_set) begin
                if (valid_reg && !pass_in.found && key_reg == pass_in.key) begin
                    value_next      = pass_in.data;
                    age_next        = 4'd0;
                    pass_next.found = 1'b1;
                end else if (!valid_reg && !pass_in.free_ok) begin
                    pass_next.free_ok  = 1'b1;
                    pass_next.free_idx = cell_idx;
                end
                if (valid_reg) begin
                    pass_next.cnt = pass_in.cnt + astr_pkg::CNT_W'(1);
                end
            end else if (valid_reg) begin
                if (age_reg < age_limit) begin
                    pass_next.data = pass_in.is_and ? (pass_in.data & value_reg)
                                                    : (pass_in.data | value_reg);
                    age_next       = age_reg + 4'd1;
                    pass_next.cnt  = pass_in.cnt + astr_pkg::CNT_W'(1);
                end else begin
                    valid_next = 1'b0;
                end
            end
        end
        // A missed set lands in this cell once the walk is over.
        if (fill_en) begin
            valid_next = 1'b1;
            key_next   = fill.key;
            value_next = fill.value;
            age_next   = 4'd0;
        end
    end

    // Control state: entry valid bit and token presence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            pass_reg.active <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pass_reg  <= pass_next;
        end
    end

    // Entry payload.
    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign pass_out = pass_reg;

endmodule

@@ rtl/astr_ctrl.sv @@
// Input handling, name hash, token launch, result staging and age limit register.
module astr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [7:0]            s_name_byte,
    input  logic                  s_last_byte,
    input  logic [31:0]           s_new_value,
    output logic [3:0]            age_limit,
    output astr_pkg::pass_t       launch,
    input  astr_pkg::pass_t       tail,
    output astr_pkg::fill_t       fill,
    output logic                  m_valid,
    input  logic                  m_ready,
    output astr_pkg::result_t     m_result
);

    logic [3:0]  age_limit_reg;
    logic [31:0] hash_reg, hash_next;
    logic        inflight_reg, inflight_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        m_valid_reg, m_valid_next;
    astr_pkg::result_t pend_reg, pend_next;
    astr_pkg::result_t out_reg, out_next;
    astr_pkg::pass_t   launch_reg, launch_next;
    astr_pkg::result_t tail_res;
    logic        accept;
    logic        is_query;
    logic        set_done;
    logic        out_free;

    assign s_ready  = !inflight_reg && !pend_valid_reg;
    assign accept   = s_valid && s_ready;
    assign is_query = (s_op == astr_pkg::OP_AND) || (s_op == astr_pkg::OP_OR);
    assign set_done = (s_op == astr_pkg::OP_BYTE) && s_last_byte;
    assign out_free = !m_valid_reg || m_ready;

    // Running hash: hash * 97 + byte, back to zero when a set completes.
    always_comb begin
        hash_next = hash_reg;
        if (accept && s_op == astr_pkg::OP_BYTE) begin
            hash_next = set_done ? 32'd0
                                 : 32'(hash_reg * astr_pkg::HASH_MUL) + 32'(s_name_byte);
        end
    end

    // Token for the chain, launched by a query or by the last name byte.
    always_comb begin
        launch_next          = launch_reg;
        launch_next.active   = accept && (is_query || set_done);
        launch_next.is_set   = set_done;
        launch_next.is_and   = (s_op == astr_pkg::OP_AND);
        launch_next.key      = 32'(hash_reg * astr_pkg::HASH_MUL) + 32'(s_name_byte);
        launch_next.data     = set_done ? s_new_value
                             : ((s_op == astr_pkg::OP_AND) ? astr_pkg::AND_SEED : 32'd0);
        launch_next.cnt      = '0;
        launch_next.found    = 1'b0;
        launch_next.free_ok  = 1'b0;
        launch_next.free_idx = '0;
    end

    // Result of a finished walk, and the write of a new entry on a miss.
    always_comb begin
        fill.en    = tail.active && tail.is_set && !tail.found && tail.free_ok;
        fill.idx   = tail.free_idx;
        fill.key   = tail.key;
        fill.value = tail.data;
        tail_res.reduced_value = tail.is_set ? 32'd0 : tail.data;
        tail_res.live_count    = 5'(tail.cnt);
        if (!tail.is_set) begin
            tail_res.status = astr_pkg::STAT_QUERY;
        end else if (tail.found) begin
            tail_res.status = astr_pkg::STAT_STORED;
        end else if (tail.free_ok) begin
            tail_res.status     = astr_pkg::STAT_STORED;
            tail_res.live_count = 5'(tail.cnt + astr_pkg::CNT_W'(1));
        end else begin
            tail_res.status = astr_pkg::STAT_FULL;
        end
    end

    // Busy tracking and the hand-off from the staging register to the output.
    always_comb begin
        inflight_next   = inflight_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        if (launch_next.active) begin
            inflight_next = 1'b1;
        end
        if (out_free) begin
            m_valid_next    = pend_valid_reg;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        if (tail.active) begin
            inflight_next   = 1'b0;
            pend_valid_next = 1'b1;
            pend_next       = tail_res;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_limit_reg     <= astr_pkg::AGE_LIMIT_RESET;
            hash_reg          <= 32'd0;
            inflight_reg      <= 1'b0;
            pend_valid_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
            launch_reg.active <= 1'b0;
        end else begin
            if (cfg_we) begin
                age_limit_reg <= cfg_wdata;
            end
            hash_reg       <= hash_next;
            inflight_reg   <= inflight_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            launch_reg     <= launch_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign age_limit = age_limit_reg;
    assign launch    = launch_reg;
    assign m_valid   = m_valid_reg;
    assign m_result  = out_reg;

endmodule

@@ rtl/aging_state_table_reducer.sv @@
// Top level of the aging state table reducer: controller and chain of entry cells.
//
// Name bytes of a set that are not the last are taken one per cycle while the
// input is open and only advance the hash. The last byte of a set and every AND
// or OR query send a token down the chain of ENTRIES cells, one cell per cycle.
// Its result passes through the launch register, the register of every cell in
// the chain and the staging register on its way to the output register. The
// next item is taken only after the result has left the staging register, so a
// stalled output, which keeps the result there, holds the input closed. No input
// item is taken while a token is in the chain or a result waits in the staging
// register, but queries as well as name bytes are taken while a result waits at
// the output. age_limit is to be written through cfg_we and cfg_wdata only while
// the block is idle; the block leaves this rule to the user.
module aging_state_table_reducer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_name_byte,
    input  logic        s_last_byte,
    input  logic [31:0] s_new_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_reduced_value,
    output logic [1:0]  m_status,
    output logic [4:0]  m_live_count
);

    astr_pkg::pass_t   chain [astr_pkg::ENTRIES+1];
    astr_pkg::fill_t   fill;
    astr_pkg::result_t result;
    logic [3:0]        age_limit;

    // Controller.
    astr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_name_byte (s_name_byte),
        .s_last_byte (s_last_byte),
        .s_new_value (s_new_value),
        .age_limit   (age_limit),
        .launch      (chain[0]),
        .tail        (chain[astr_pkg::ENTRIES]),
        .fill        (fill),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (result)
    );

    // Chain of entry cells, lowest index first.
    for (genvar i = 0; i < astr_pkg::ENTRIES; i++) begin : g_cell
        astr_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (astr_pkg::IDX_W'(i)),
            .age_limit (age_limit),
            .pass_in   (chain[i]),
            .fill_en   (fill.en && fill.idx == astr_pkg::IDX_W'(i)),
            .fill      (fill),
            .pass_out  (chain[i+1])
        );
    end

    assign m_reduced_value = result.reduced_value;
    assign m_status        = result.status;
    assign m_live_count    = result.live_count;

endmodule

@@ rtl/astr_checker.sv @@
// Port-level checks for the aging state table reducer, bound to the top level.
module astr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_op,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_reduced_value,
    input logic [1:0]  m_status,
    input logic [4:0]  m_live_count
);

    // A stalled result item stays valid and keeps its reduced value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reduced_value))
        else $error("result item dropped or changed while stalled");

    // A query occupies the table, so the input closes right after it.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == astr_pkg::OP_AND || s_op == astr_pkg::OP_OR)
        |=> !s_ready)
        else $error("input open while a query walks the table");

    // A set reports no reduced value.
    a_set_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != astr_pkg::STAT_QUERY |-> m_reduced_value == 32'd0)
        else $error("set result carries a reduced value");

    // A set is dropped only when every entry is live.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == astr_pkg::STAT_FULL |-> m_live_count == 5'(astr_pkg::ENTRIES))
        else $error("set dropped while a slot was free");

endmodule

bind aging_state_table_reducer astr_checker u_astr_checker (.*);

@@ tb/sv/aging_state_table_reducer_tb.sv @@
// Self-checking testbench for the aging state table reducer, with a built-in table predictor.
module aging_state_table_reducer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Op code 3 has no member in the package enum; the block ignores it.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NAME_COUNT        = 24;
    localparam int SETTLE_CYCLES     = astr_pkg::ENTRIES + 3 + 12;
    localparam int RESULT_HOLD       = 300;
    localparam int QUIET_LIMIT       = 4000;

    // One expected result item.
    typedef struct {
        logic [31:0]       folded;
        astr_pkg::status_t status;
        logic [4:0]        live;
    } table_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [7:0]  s_name_byte;
    logic        s_last_byte;
    logic [31:0] s_new_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_reduced_value;
    logic [1:0]  m_status;
    logic [4:0]  m_live_count;

    // Predictor copy of the table, the name hash and the age limit.
    logic [31:0] name_hash;
    logic        tbl_valid [astr_pkg::ENTRIES];
    logic [31:0] tbl_key   [astr_pkg::ENTRIES];
    logic [31:0] tbl_value [astr_pkg::ENTRIES];
    logic [3:0]  tbl_age   [astr_pkg::ENTRIES];
    logic [3:0]  age_limit_model;

    table_result_t pending_results[$];

    // Pool of entry names used by the random part.
    logic [7:0] name_bytes [NAME_COUNT][4];
    int         name_len   [NAME_COUNT];

    // Pacing controls shared by the sender, the receiver and the tests.
    int next_gap      = 0;
    bit tx_quiet      = 1'b0;
    bit rx_quiet      = 1'b0;
    int rx_hold_cycles = 0;

    int items_sent      = 0;
    int results_checked = 0;
    int sets_dropped    = 0;
    int settings_used   = 0;
    int mismatches      = 0;

    aging_state_table_reducer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_name_byte     (s_name_byte),
        .s_last_byte     (s_last_byte),
        .s_new_value     (s_new_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reduced_value (m_reduced_value),
        .m_status        (m_status),
        .m_live_count    (m_live_count)
    );

    always #2 aclk = ~aclk;

    // Applies one accepted item to the predicted table and queues its result, if any.
    function automatic void apply_to_table(input logic [1:0] op, input logic [7:0] nb,
                                           input logic last, input logic [31:0] val);
        table_result_t res;
        int            slot;
        logic [31:0]   key;
        logic [31:0]   acc;
        logic [4:0]    live;
        slot = -1;
        live = '0;
        if (op == astr_pkg::OP_BYTE) begin
            name_hash = name_hash * astr_pkg::HASH_MUL + {24'd0, nb};
            if (!last) return;
            key       = name_hash;
            name_hash = '0;
            // A matching live key wins; otherwise the lowest free slot.
            for (int i = 0; i < astr_pkg::ENTRIES; i++) begin
                if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
            end
            for (int i = 0; i < astr_pkg::ENTRIES; i++) begin
                if (slot < 0 && !tbl_valid[i]) slot = i;
            end
            res.folded = '0;
            if (slot >= 0) begin
                tbl_valid[slot] = 1'b1;
                tbl_key[slot]   = key;
                tbl_value[slot] = val;
                tbl_age[slot]   = '0;
                res.status      = astr_pkg::STAT_STORED;
            end else begin
                res.status = astr_pkg::STAT_FULL;
                sets_dropped++;
            end
        end else if (op == astr_pkg::OP_AND || op == astr_pkg::OP_OR) begin
            // Young entries are folded and aged; the rest are removed.
            acc = (op == astr_pkg::OP_AND) ? astr_pkg::AND_SEED : '0;
            for (int i = 0; i < astr_pkg::ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (tbl_age[i] < age_limit_model) begin
                        acc        = (op == astr_pkg::OP_AND) ? (acc & tbl_value[i])
                                                              : (acc | tbl_value[i]);
                        tbl_age[i] = tbl_age[i] + 4'd1;
                    end else begin
                        tbl_valid[i] = 1'b0;
                    end
                end
            end
            res.folded = acc;
            res.status = astr_pkg::STAT_QUERY;
        end else begin
            return;
        end
        for (int i = 0; i < astr_pkg::ENTRIES; i++) begin
            if (tbl_valid[i]) live++;
        end
        res.live = live;
        pending_results.push_back(res);
    endfunction

    // Offers one item and waits until it is accepted; called at a falling edge.
    task automatic send_item(input logic [1:0] op, input logic [7:0] nb, input logic last,
                             input logic [31:0] val);
        repeat (next_gap) @(negedge aclk);
        s_op        = op;
        s_name_byte = nb;
        s_last_byte = last;
        s_new_value = val;
        s_valid     = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_to_table(op, nb, last, val);
        if (op != OP_UNUSED) items_sent++;
        @(negedge aclk);
        // Valid stays high only when the next item follows at once.
        next_gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (next_gap != 0) s_valid = 1'b0;
    endtask

    // Sends an AND or OR query with random don't-care fields.
    task automatic send_query();
        logic [1:0] op;
        op = $urandom_range(0, 1) ? astr_pkg::OP_AND : astr_pkg::OP_OR;
        send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom());
    endtask

    // Streams one pool name as a set, optionally with a query before its last byte.
    task automatic send_name_set(input int idx, input logic [31:0] val, input bit mid_query);
        int last_i;
        last_i = name_len[idx] - 1;
        for (int i = 0; i <= last_i; i++) begin
            if (mid_query && i == last_i) send_query();
            send_item(astr_pkg::OP_BYTE, name_bytes[idx][i], i == last_i,
                      (i == last_i) ? val : $urandom());
        end
    endtask

    // Lets every expected result arrive and the block go quiet.
    task automatic wait_for_results();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_age_limit(input logic [3:0] limit);
        wait_for_results();
        cfg_wdata = limit;
        cfg_we    = 1'b1;
        @(negedge aclk);
        cfg_we          = 1'b0;
        age_limit_model = limit;
        settings_used++;
    endtask

    // Sets, overwrites, both queries, an ignored op code and a query inside a set.
    task automatic test_basic_ops();
        send_item(astr_pkg::OP_BYTE, 8'h00, 1'b1, 32'hFFFF_FFFF);
        send_item(astr_pkg::OP_BYTE, 8'hFF, 1'b0, 32'h0BAD_0BAD);
        send_item(astr_pkg::OP_BYTE, 8'h00, 1'b1, 32'h0000_0000);
        send_item(astr_pkg::OP_AND, 8'h00, 1'b0, 32'h0000_0000);
        send_item(astr_pkg::OP_OR, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_item(astr_pkg::OP_BYTE, 8'h00, 1'b1, 32'h8000_0001);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_item(astr_pkg::OP_BYTE, 8'h41, 1'b0, 32'h0);
        send_item(astr_pkg::OP_OR, 8'h55, 1'b0, 32'h0);
        send_item(astr_pkg::OP_BYTE, 8'h42, 1'b1, 32'h1234_5678);
        send_item(astr_pkg::OP_AND, 8'hAA, 1'b1, 32'h0);
    endtask

    // An age limit of zero clears the table on the next query; one allows a single query.
    task automatic test_age_limit_edges();
        write_age_limit(4'd0);
        send_item(astr_pkg::OP_OR, 8'h00, 1'b0, 32'h0);
        write_age_limit(4'd1);
        send_item(astr_pkg::OP_BYTE, 8'h7F, 1'b1, 32'hA5A5_5A5A);
        send_item(astr_pkg::OP_AND, 8'h00, 1'b0, 32'h0);
        send_item(astr_pkg::OP_OR, 8'h00, 1'b0, 32'h0);
    endtask

    // Seventeen distinct keys overflow the table; a known key still updates.
    task automatic test_table_full();
        write_age_limit(4'd15);
        for (int i = 0; i < astr_pkg::ENTRIES + 1; i++) begin
            send_item(astr_pkg::OP_BYTE, 8'h80 + i[7:0], 1'b1, $urandom());
        end
        send_item(astr_pkg::OP_BYTE, 8'h85, 1'b1, 32'hFFFF_FFFF);
        send_item(astr_pkg::OP_OR, 8'h00, 1'b0, 32'h0);
    endtask

    // Mostly well-formed sets and queries, with stray bytes and unused op codes mixed in.
    task automatic random_phase(input int count);
        int goal;
        int pick;
        goal = items_sent + count;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_name_set($urandom_range(0, NAME_COUNT - 1), $urandom(), 1'b0);
            end else if (pick < 62) begin
                send_name_set($urandom_range(0, NAME_COUNT - 1), $urandom(), 1'b1);
            end else if (pick < 85) begin
                send_query();
            end else if (pick < 91) begin
                // Stray bytes fold into the hash of whatever set follows.
                repeat ($urandom_range(1, 2))
                    send_item(astr_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b0,
                              $urandom());
            end else if (pick < 96) begin
                send_item(astr_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b1, $urandom());
            end else begin
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          $urandom());
            end
        end
    endtask

    // Random traffic under a series of age limits, one phase without any idling.
    task automatic test_random_settings();
        logic [3:0] limits [6];
        limits = '{4'd15, 4'd1, 4'd2, 4'($urandom_range(0, 15)), 4'd5,
                   4'($urandom_range(1, 15))};
        for (int n = 0; n < NAME_COUNT; n++) begin
            name_len[n]      = $urandom_range(1, 4);
            name_bytes[n][0] = n[7:0];
            for (int b = 1; b < 4; b++) name_bytes[n][b] = 8'($urandom_range(0, 255));
        end
        for (int p = 0; p < 6; p++) begin
            write_age_limit(limits[p]);
            tx_quiet = (p == 2);
            rx_quiet = (p == 2);
            random_phase(65);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_result_stall();
        wait_for_results();
        rx_hold_cycles = RESULT_HOLD;
        tx_quiet       = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 0) send_query();
            else send_item(astr_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b1, $urandom());
        end
        tx_quiet = 1'b0;
        wait_for_results();
    endtask

    // Receiver: random hold-off per item, plus one long stall when a test asks.
    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            hold = rx_quiet ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                m_ready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    // Each accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: reduced_value %h status %0d live_count %0d",
                       m_reduced_value, m_status, m_live_count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_reduced_value !== want.folded) begin
                    $error("reduced_value: expected %h, actual %h", want.folded, m_reduced_value);
                    mismatches++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_live_count !== want.live) begin
                    $error("live_count: expected %0d, actual %0d", want.live, m_live_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no item accepted for %0d cycles.", QUIET_LIMIT);
        $display("** aging_state_table_reducer: FAILED **");
        $finish;
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_op        = astr_pkg::OP_BYTE;
        s_name_byte = '0;
        s_last_byte = 1'b0;
        s_new_value = '0;
        name_hash       = '0;
        age_limit_model = astr_pkg::AGE_LIMIT_RESET;
        for (int i = 0; i < astr_pkg::ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_age[i]   = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_basic_ops();
        test_age_limit_edges();
        test_table_full();
        test_random_settings();
        test_result_stall();

        wait_for_results();
        $display("Sent %0d items and checked %0d results over %0d age_limit settings.",
                 items_sent, results_checked, settings_used);
        $display("Covered %0d sets dropped on a full table and a %0d-cycle result stall.",
                 sets_dropped, RESULT_HOLD);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** aging_state_table_reducer: PASSED **");
        end else begin
            $display("** aging_state_table_reducer: FAILED **");
        end
        $finish;
    end

endmodule
